>>> src/fida_pkg.sv
// Package for the FIFO ID allocator: sizes, opcodes, payload and control types.
package fida_pkg;

    // Pool size (power of two); IDs and pointers wrap modulo this depth
    localparam int POOL_DEPTH = 1024;
    localparam int ID_W       = $clog2(POOL_DEPTH);
    localparam int CNT_W      = ID_W + 1;

    // Configuration port
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;
    localparam int CFG_COUNT_W = 11;
    localparam logic [PADDR_W-3:0] REG_NUMBER_COUNT = '0;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(POOL_DEPTH);

    // Operation codes
    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_CHECK   = 2'd1,
        OP_RELEASE = 2'd2
    } opcode_t;

    typedef struct packed {
        logic [1:0]      opcode;
        logic [ID_W-1:0] id_number;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0] given_id;
        logic            success;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic init_step;
        logic capture;
        logic exec;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic init_last;
        logic out_free;
    } dp_status_t;

endpackage

>>> src/fifo_id_allocator_top.sv
// Top level of the FIFO ID allocator: configuration port, controller and datapath.
//
//  channel  | ports                              | direction | payload
//  ---------+------------------------------------+-----------+-------------------------
//  request  | s_valid, s_ready, s_payload        | in        | opcode, id_number
//  result   | m_valid, m_ready, m_payload        | out       | given_id, success
//  config   | psel, penable, pwrite, paddr, ...  | in/out    | number_count at byte 0
//
// Each item is accepted, then executed: the accept edge reads both memories, and the
// execute state loads the result register; one memory read-modify-write per item.
// After reset and after every number_count write, an init sweep over all 1024 entries
// rebuilds the free list and the availability map; no request is taken meanwhile.
// A waiting result does not block the next accept; execute waits for a free result slot.
module fifo_id_allocator_top
    import fida_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // config
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // request
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_payload,
    // result
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_payload
);

    ctrl_cmd_t        cmd;
    dp_status_t       status;
    logic             cfg_we;
    logic             reg_hit;
    logic [CNT_W-1:0] pool_count;

    // Register decode
    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_NUMBER_COUNT);
    assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? PDATA_W'(pool_count) : '0;

    fida_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_we  (cfg_we),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    fida_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_count  (pwdata[CFG_COUNT_W-1:0]),
        .pool_count (pool_count),
        .cmd        (cmd),
        .status     (status),
        .s_payload  (s_payload),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

endmodule

>>> src/fida_ctrl.sv
// Controller state machine of the FIFO ID allocator.
module fida_ctrl
    import fida_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       s_valid,
    output logic       s_ready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    // Commands decoded from the current state
    always_comb begin
        cmd.init_step = (state_reg == ST_INIT);
        cmd.capture   = s_valid && s_ready_reg;
        cmd.exec      = (state_reg == ST_EXEC) && status.out_free;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        if (cfg_we) begin
            state_next = ST_INIT;
        end else begin
            unique case (state_reg)
                ST_INIT: begin
                    if (status.init_last) state_next = ST_IDLE;
                end
                ST_IDLE: begin
                    if (cmd.capture) state_next = ST_EXEC;
                end
                ST_EXEC: begin
                    if (status.out_free) state_next = ST_IDLE;
                end
                default: state_next = ST_INIT;
            endcase
        end
        s_ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    assign s_ready = s_ready_reg;

`ifndef NO_ASSERTIONS
    // No item is taken while the pool is being rebuilt
    a_no_capture_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INIT) |-> !cmd.capture)
        else $error("item accepted during init sweep");

    // An accepted item always moves the controller to the execute state unless a config write intervenes
    a_capture_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.capture && !cfg_we) |=> (state_reg == ST_EXEC))
        else $error("accepted item not executed");

    // While an item is in flight no new item is taken
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |-> !s_ready)
        else $error("ready while item in flight");
`endif

endmodule

>>> src/fida_datapath.sv
// Datapath of the FIFO ID allocator: free list, availability map, pointers, result register.
module fida_datapath
    import fida_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CFG_COUNT_W-1:0] cfg_count,
    output logic [CNT_W-1:0] pool_count,
    input  ctrl_cmd_t        cmd,
    output dp_status_t       status,
    input  in_item_t         s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_payload
);

    // Storage
    logic [ID_W-1:0] fl_mem [POOL_DEPTH];
    logic            map_mem [POOL_DEPTH];

    logic [CNT_W-1:0] pool_count_reg;
    logic [CNT_W-1:0] free_count_reg, free_count_next;
    logic [ID_W-1:0]  head_reg, head_next;
    logic [ID_W-1:0]  tail_reg, tail_next;
    logic [ID_W-1:0]  init_idx_reg;

    logic [1:0]       op_reg;
    logic [ID_W-1:0]  id_reg;
    logic [ID_W-1:0]  fl_rdata_reg;
    logic             map_rdata_reg;

    logic             m_valid_reg;
    out_item_t        m_payload_reg, m_payload_next;

    logic             fl_we;
    logic [ID_W-1:0]  fl_waddr, fl_wdata;
    logic             map_we, map_wdata;
    logic [ID_W-1:0]  map_waddr;

    logic [CNT_W-1:0] cfg_sat;
    logic             id_in_pool;

    // Saturate the written count to the pool depth
    assign cfg_sat = (CNT_W'(cfg_count) > COUNT_RESET) ? COUNT_RESET : CNT_W'(cfg_count);
    assign id_in_pool = ({1'b0, id_reg} < pool_count_reg);

    assign status.init_last = (init_idx_reg == ID_W'(POOL_DEPTH - 1));
    assign status.out_free  = !m_valid_reg || m_ready;

    // Init writes and operation execute: memory writes, pointer updates, result
    always_comb begin
        fl_we           = 1'b0;
        fl_waddr        = tail_reg;
        fl_wdata        = id_reg;
        map_we          = 1'b0;
        map_waddr       = id_reg;
        map_wdata       = 1'b1;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_count_next = free_count_reg;
        m_payload_next  = '0;

        if (cmd.init_step) begin
            fl_we     = 1'b1;
            fl_waddr  = init_idx_reg;
            fl_wdata  = init_idx_reg;
            map_we    = 1'b1;
            map_waddr = init_idx_reg;
            map_wdata = ({1'b0, init_idx_reg} < pool_count_reg);
        end else if (cmd.exec) begin
            case (op_reg)
                OP_GET: begin
                    if (free_count_reg != '0) begin
                        map_we                  = 1'b1;
                        map_waddr               = fl_rdata_reg;
                        map_wdata               = 1'b0;
                        head_next               = head_reg + 1'b1;
                        free_count_next         = free_count_reg - 1'b1;
                        m_payload_next.given_id = fl_rdata_reg;
                        m_payload_next.success  = 1'b1;
                    end
                end
                OP_CHECK: begin
                    m_payload_next.success = id_in_pool && map_rdata_reg;
                end
                OP_RELEASE: begin
                    if (id_in_pool && !map_rdata_reg) begin
                        map_we                 = 1'b1;
                        fl_we                  = 1'b1;
                        tail_next              = tail_reg + 1'b1;
                        free_count_next        = free_count_reg + 1'b1;
                        m_payload_next.success = 1'b1;
                    end
                end
                default: m_payload_next = '0;
            endcase
        end
    end

    // Memories: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (fl_we) fl_mem[fl_waddr] <= fl_wdata;
        if (cmd.capture) fl_rdata_reg <= fl_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (map_we) map_mem[map_waddr] <= map_wdata;
        if (cmd.capture) map_rdata_reg <= map_mem[s_payload.id_number];
    end

    // Captured item
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg <= s_payload.opcode;
            id_reg <= s_payload.id_number;
        end
    end

    // Pool control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_count_reg <= COUNT_RESET;
            free_count_reg <= COUNT_RESET;
            head_reg       <= '0;
            tail_reg       <= COUNT_RESET[ID_W-1:0];
            init_idx_reg   <= '0;
        end else if (cfg_we) begin
            pool_count_reg <= cfg_sat;
            free_count_reg <= cfg_sat;
            head_reg       <= '0;
            tail_reg       <= cfg_sat[ID_W-1:0];
            init_idx_reg   <= '0;
        end else begin
            free_count_reg <= free_count_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            if (cmd.init_step) init_idx_reg <= init_idx_reg + 1'b1;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) m_payload_reg <= m_payload_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_payload  = m_payload_reg;
    assign pool_count = pool_count_reg;

`ifndef NO_ASSERTIONS
    // Free list never holds more IDs than the pool has
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= pool_count_reg)
        else $error("free count above pool count");

    // Pointer distance tracks the free count
    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ID_W'(tail_reg - head_reg) == free_count_reg[ID_W-1:0])
        else $error("pointers and free count disagree");

    // A result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");
`endif

endmodule
